// File: rtl/bavg_pkg.sv
// ----------------------------------------------------------------------------
// Block average downscaler package
// Shared constants, register indexes and item types of the downscaler.
// ----------------------------------------------------------------------------
package bavg_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_SCALE_DEF = 8;
	localparam int MAX_HEIGHT    = 4096;

	localparam int CHAN_W   = 8;
	localparam int SCALE_W  = 4;
	localparam int LWIDTH_W = 11;
	localparam int HEIGHT_W = 13;
	localparam int ROW_W    = 12;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [1:0] REG_SCALE  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd2;
	localparam logic [LWIDTH_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              row_end;
		logic              frame_end;
	} pix_out_t;

endpackage

// File: rtl/bavg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/block_average_downscaler.sv
// ----------------------------------------------------------------------------
// Block average downscaler
// Averages each square block of RGB pixels, ignoring black ones, into one
// output pixel. Per-column partial sums live in a line store RAM.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data  (pix_in_t)
//   out       output     out_valid/out_stall out_data (pix_out_t)
//   config    input      APB write/read      paddr, pwdata, prdata
//
// Each item is accepted, then read-modify-written into the line store.
// An item that closes a block then goes through the shared divider's
// quotient steps and then loads the output register, which may wait
// further while out_stall holds the previous result.
// in_stall is high from the accept until the item is finished.
// Reset clears the position counters and loads the register defaults; the
// line store is not cleared.
// ----------------------------------------------------------------------------
module block_average_downscaler #(
	parameter int MAX_WIDTH = bavg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = bavg_pkg::MAX_SCALE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bavg_pkg::PADDR_W-1:0] paddr,
	input  logic [bavg_pkg::PDATA_W-1:0] pwdata,
	output logic [bavg_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bavg_pkg::pix_in_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output bavg_pkg::pix_out_t           out_data
);

	localparam int CHAN_W = bavg_pkg::CHAN_W;
	localparam int OC_W   = $clog2(MAX_WIDTH);
	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int SCL_W  = $clog2(MAX_SCALE + 1);
	localparam int PH_W   = $clog2(MAX_SCALE);
	localparam int CNT_W  = $clog2(MAX_SCALE * MAX_SCALE + 1);
	localparam int SUM_W  = $clog2(255 * MAX_SCALE * MAX_SCALE + 1);
	localparam int ENT_W  = 3 * SUM_W + CNT_W;
	localparam int PROD_W = OC_W + 1 + SCL_W;
	localparam int CMP_W  = PROD_W + 1;
	localparam int ROW_W  = bavg_pkg::ROW_W;
	localparam int HC_W   = ROW_W + 2;
	localparam int TR_W   = SUM_W + CHAN_W;
	localparam int BIT_W  = $clog2(CHAN_W);
	localparam int H_W    = bavg_pkg::HEIGHT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [bavg_pkg::SCALE_W-1:0]  scale_q;
	logic [bavg_pkg::LWIDTH_W-1:0] width_q;
	logic [H_W-1:0]                height_q;

	logic [SCL_W-1:0] s_c;
	logic [W_W-1:0]   w_c;
	logic [H_W-1:0]   h_c;

	logic [1:0]       state_q;
	logic [OC_W-1:0]  cpos_q;
	logic [OC_W-1:0]  oc_q;
	logic [ROW_W-1:0] rpos_q;
	logic [PH_W-1:0]  cph_q;
	logic [PH_W-1:0]  rph_q;

	bavg_pkg::pix_in_t pix_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [ENT_W-1:0] rd_ent;
	logic [ENT_W-1:0] new_ent;
	logic             ram_we;

	logic [SUM_W-1:0]  rem_q [3];
	logic [CHAN_W-1:0] quo_q [3];
	logic [CNT_W-1:0]  dcnt_q;
	logic [BIT_W-1:0]  bit_q;
	logic              zero_q;
	logic              rend_q;
	logic              fend_q;

	logic               out_valid_q;
	bavg_pkg::pix_out_t out_data_q;

	logic             accept;
	logic             wr_cfg;
	logic             col_wrap;
	logic             row_wrap;
	logic             cph_last;
	logic             rph_last;
	logic             first_px;
	logic             nonblack;
	logic             in_col;
	logic             in_row;
	logic             row_end_c;
	logic             frame_end_c;
	logic [ROW_W-1:0] row_start;
	logic             load_out;

	logic [SUM_W-1:0]  base_sum [3];
	logic [SUM_W-1:0]  new_sum [3];
	logic [CNT_W-1:0]  base_cnt;
	logic [CNT_W-1:0]  new_cnt;
	logic [CHAN_W-1:0] pix_ch [3];
	logic [TR_W-1:0]   trial;
	logic              ge [3];

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && pready;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		case (paddr[3:2])
			bavg_pkg::REG_SCALE:  prdata = bavg_pkg::PDATA_W'(scale_q);
			bavg_pkg::REG_WIDTH:  prdata = bavg_pkg::PDATA_W'(width_q);
			bavg_pkg::REG_HEIGHT: prdata = bavg_pkg::PDATA_W'(height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		if (scale_q == '0) begin
			s_c = SCL_W'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			s_c = SCL_W'(MAX_SCALE);
		end else begin
			s_c = SCL_W'(scale_q);
		end
		if (width_q == '0) begin
			w_c = W_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_c = W_W'(MAX_WIDTH);
		end else begin
			w_c = W_W'(width_q);
		end
		if (height_q == '0) begin
			h_c = H_W'(1);
		end else if (32'(height_q) > 32'(bavg_pkg::MAX_HEIGHT)) begin
			h_c = H_W'(bavg_pkg::MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
	end

	assign col_wrap = (CMP_W'(cpos_q) + CMP_W'(1)) >= CMP_W'(w_c);
	assign row_wrap = (HC_W'(rpos_q) + HC_W'(1)) >= HC_W'(h_c);
	assign cph_last = (SCL_W'(cph_q) + SCL_W'(1)) >= s_c;
	assign rph_last = (SCL_W'(rph_q) + SCL_W'(1)) >= s_c;
	assign first_px = (cph_q == '0) && (rph_q == '0);
	assign row_start = rpos_q - ROW_W'(rph_q);
	assign in_row = (HC_W'(row_start) + HC_W'(s_c)) <= HC_W'(h_c);
	assign in_col = CMP_W'(prod_s1) <= CMP_W'(w_c);
	assign row_end_c = (CMP_W'(prod_s1) + CMP_W'(s_c)) > CMP_W'(w_c);
	assign frame_end_c = row_end_c &&
		((HC_W'(row_start) + HC_W'(s_c) + HC_W'(s_c)) > HC_W'(h_c));

	assign pix_ch[0] = pix_s1.in_red;
	assign pix_ch[1] = pix_s1.in_green;
	assign pix_ch[2] = pix_s1.in_blue;
	assign nonblack = (pix_s1.in_red | pix_s1.in_green | pix_s1.in_blue) != '0;

	always_comb begin
		base_sum[0] = first_px ? '0 : rd_ent[ENT_W-1 -: SUM_W];
		base_sum[1] = first_px ? '0 : rd_ent[ENT_W-SUM_W-1 -: SUM_W];
		base_sum[2] = first_px ? '0 : rd_ent[ENT_W-2*SUM_W-1 -: SUM_W];
		base_cnt = first_px ? '0 : rd_ent[CNT_W-1:0];
		for (int i = 0; i < 3; i++) begin
			new_sum[i] = base_sum[i] + (nonblack ? SUM_W'(pix_ch[i]) : '0);
		end
		new_cnt = base_cnt + CNT_W'(nonblack);
	end

	assign new_ent = {new_sum[0], new_sum[1], new_sum[2], new_cnt};
	assign ram_we = (state_q == ST_MOD) && in_col && in_row;

	bavg_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(oc_q),
		.wdata(new_ent),
		.raddr(oc_q),
		.rdata(rd_ent)
	);

	always_comb begin
		trial = TR_W'(dcnt_q) << bit_q;
		for (int i = 0; i < 3; i++) begin
			ge[i] = TR_W'(rem_q[i]) >= trial;
		end
	end

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= bavg_pkg::SCALE_RST;
			width_q <= bavg_pkg::WIDTH_RST;
			height_q <= bavg_pkg::HEIGHT_RST;
		end else if (wr_cfg) begin
			case (paddr[3:2])
				bavg_pkg::REG_SCALE:  scale_q <= pwdata[bavg_pkg::SCALE_W-1:0];
				bavg_pkg::REG_WIDTH:  width_q <= pwdata[bavg_pkg::LWIDTH_W-1:0];
				bavg_pkg::REG_HEIGHT: height_q <= pwdata[H_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cpos_q <= '0;
			oc_q <= '0;
			rpos_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (in_col && in_row && cph_last && rph_last) begin
						state_q <= ST_DIV;
						bit_q <= BIT_W'(CHAN_W - 1);
					end else begin
						state_q <= ST_IDLE;
					end
					if (col_wrap) begin
						cpos_q <= '0;
						cph_q <= '0;
						oc_q <= '0;
						if (row_wrap) begin
							rpos_q <= '0;
							rph_q <= '0;
						end else begin
							rpos_q <= rpos_q + ROW_W'(1);
							rph_q <= rph_last ? '0 : rph_q + PH_W'(1);
						end
					end else begin
						cpos_q <= cpos_q + OC_W'(1);
						if (cph_last) begin
							cph_q <= '0;
							oc_q <= oc_q + OC_W'(1);
						end else begin
							cph_q <= cph_q + PH_W'(1);
						end
					end
				end
				ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
			prod_s1 <= (PROD_W'(oc_q) + PROD_W'(1)) * PROD_W'(s_c);
		end
		if (state_q == ST_MOD) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= new_sum[i];
				quo_q[i] <= '0;
			end
			dcnt_q <= new_cnt;
			zero_q <= (new_cnt == '0);
			rend_q <= row_end_c;
			fend_q <= frame_end_c;
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				if (ge[i]) begin
					rem_q[i] <= rem_q[i] - trial[SUM_W-1:0];
				end
				quo_q[i][bit_q] <= ge[i];
			end
		end
		if (load_out) begin
			out_data_q.out_red <= zero_q ? '0 : quo_q[0];
			out_data_q.out_green <= zero_q ? '0 : quo_q[1];
			out_data_q.out_blue <= zero_q ? '0 : quo_q[2];
			out_data_q.row_end <= rend_q;
			out_data_q.frame_end <= fend_q;
		end
	end

endmodule

// File: rtl/bavg_checker.sv
// ----------------------------------------------------------------------------
// Block average downscaler port checker
// Watches the item channels of the downscaler over time.
// ----------------------------------------------------------------------------
module bavg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input bavg_pkg::pix_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled output item changed.");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.row_end)
		else $error("Frame end without row end.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input taken again while an item is in work.");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("Result appeared without an item in work.");

endmodule

bind block_average_downscaler bavg_checker u_bavg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// File: verif/tb_block_average_downscaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average downscaler testbench
// Drives raster-order RGB items through the valid/stall input channel and
// checks every output item against a cycle-free model of the box filter kept
// in this file. A directed table covers extremes, black handling, partial
// blocks and register clamping; then the line store is filled once and random
// register settings and pixels follow under three idling patterns.
// ----------------------------------------------------------------------------
module tb_block_average_downscaler;
	import bavg_pkg::*;

	localparam int LINGER_CYCLES = 20;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		int unsigned value;
		pix_in_t     pix;
		bit          typed;
		pix_out_t    res;
	} stim_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	pix_in_t             in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pix_out_t            out_data;

	int unsigned         sum_red   [MAX_WIDTH_DEF];
	int unsigned         sum_green [MAX_WIDTH_DEF];
	int unsigned         sum_blue  [MAX_WIDTH_DEF];
	int unsigned         pix_count [MAX_WIDTH_DEF];
	int unsigned         col_pos   = 0;
	int unsigned         row_pos   = 0;
	int unsigned         col_phase = 0;
	int unsigned         row_phase = 0;
	int unsigned         out_col   = 0;
	logic [SCALE_W-1:0]  cfg_scale  = SCALE_RST;
	logic [LWIDTH_W-1:0] cfg_width  = WIDTH_RST;
	logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RST;

	pix_out_t            expected_pixels[$];
	stim_row_t           directed_rows[$];
	int                  mismatch_count = 0;
	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;

	block_average_downscaler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic bit downscale_pixel(input pix_in_t p, output pix_out_t res);
		int unsigned s, w, h, out_cols, row_start;
		bit produced;
		s = clamp_to(32'(cfg_scale), MAX_SCALE_DEF);
		w = clamp_to(32'(cfg_width), MAX_WIDTH_DEF);
		h = clamp_to(32'(cfg_height), MAX_HEIGHT);
		out_cols = w / s;
		row_start = row_pos - row_phase;
		produced = 1'b0;
		res = '0;
		if (out_col < out_cols && out_col < MAX_WIDTH_DEF && row_start + s <= h) begin
			if (col_phase == 0 && row_phase == 0) begin
				sum_red[out_col] = 0;
				sum_green[out_col] = 0;
				sum_blue[out_col] = 0;
				pix_count[out_col] = 0;
			end
			if (p != '0) begin
				sum_red[out_col] += 32'(p.in_red);
				sum_green[out_col] += 32'(p.in_green);
				sum_blue[out_col] += 32'(p.in_blue);
				pix_count[out_col] += 1;
			end
			if (col_phase >= s - 1 && row_phase >= s - 1) begin
				if (pix_count[out_col] != 0) begin
					res.out_red = 8'(sum_red[out_col] / pix_count[out_col]);
					res.out_green = 8'(sum_green[out_col] / pix_count[out_col]);
					res.out_blue = 8'(sum_blue[out_col] / pix_count[out_col]);
				end
				res.row_end = (out_col == out_cols - 1);
				res.frame_end = res.row_end && (row_start + 2 * s > h);
				produced = 1'b1;
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			col_phase = 0;
			out_col = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				row_phase = 0;
			end else begin
				row_pos += 1;
				row_phase = (row_phase >= s - 1) ? 0 : row_phase + 1;
			end
		end else begin
			col_pos += 1;
			if (col_phase >= s - 1) begin
				col_phase = 0;
				out_col = (out_col + 1) & 32'h3FF;
			end else begin
				col_phase += 1;
			end
		end
		return produced;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input int unsigned value);
		stim_row_t row;
		row = '{is_cfg: 1'b1, reg_idx: idx, value: value, pix: '0, typed: 1'b0, res: '0};
		return row;
	endfunction

	function automatic stim_row_t pix_row(input pix_in_t pix, input bit typed,
			input pix_out_t res);
		stim_row_t row;
		row = '{is_cfg: 1'b0, reg_idx: REG_SCALE, value: 0, pix: pix, typed: typed, res: res};
		return row;
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		p = '0;
		if ($urandom_range(0, 3) != 0) begin
			p.in_red = 8'($urandom_range(0, 255));
			p.in_green = 8'($urandom_range(0, 255));
			p.in_blue = 8'($urandom_range(0, 255));
		end
		return p;
	endfunction

	task automatic send_pixel(input pix_in_t p, input bit use_typed, input pix_out_t typed);
		pix_out_t predicted;
		bit produced;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
		produced = downscale_pixel(p, predicted);
		if (produced)
			expected_pixels.push_back(use_typed ? typed : predicted);
	endtask

	task automatic apb_read(input logic [1:0] idx, output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
		logic [PDATA_W-1:0] readback;
		logic [PDATA_W-1:0] stored;
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LINGER_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SCALE: begin
				cfg_scale = value[SCALE_W-1:0];
				stored = 32'(cfg_scale);
			end
			REG_WIDTH: begin
				cfg_width = value[LWIDTH_W-1:0];
				stored = 32'(cfg_width);
			end
			REG_HEIGHT: begin
				cfg_height = value[HEIGHT_W-1:0];
				stored = 32'(cfg_height);
			end
			default: begin
				stored = value;
			end
		endcase
		@(posedge clk);
		apb_read(idx, readback);
		check_field("register readback", stored, readback);
	endtask

	always @(posedge clk) begin : collect
		pix_out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected item, expected none, actual %h", $time, out_data);
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_red", 32'(want.out_red), 32'(out_data.out_red));
				check_field("out_green", 32'(want.out_green), 32'(out_data.out_green));
				check_field("out_blue", 32'(want.out_blue), 32'(out_data.out_blue));
				check_field("row_end", 32'(want.row_end), 32'(out_data.row_end));
				check_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		logic [PDATA_W-1:0] rd;
		int unsigned        s, w, h, pick;

		// One pixel per frame: the output item is the pixel itself.
		directed_rows.push_back(cfg_row(REG_SCALE, 1));
		directed_rows.push_back(cfg_row(REG_WIDTH, 1));
		directed_rows.push_back(cfg_row(REG_HEIGHT, 1));
		directed_rows.push_back(pix_row({8'hFF, 8'hFF, 8'hFF}, 1'b1,
			{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}));
		directed_rows.push_back(pix_row({8'h00, 8'h00, 8'h00}, 1'b1,
			{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}));
		directed_rows.push_back(pix_row({8'hAA, 8'h55, 8'hAA}, 1'b1,
			{8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1}));
		directed_rows.push_back(pix_row({8'h55, 8'hAA, 8'h55}, 1'b1,
			{8'h55, 8'hAA, 8'h55, 1'b1, 1'b1}));
		// Zero scale, width and height all behave as one.
		directed_rows.push_back(cfg_row(REG_SCALE, 0));
		directed_rows.push_back(pix_row({8'd7, 8'd8, 8'd9}, 1'b1,
			{8'd7, 8'd8, 8'd9, 1'b1, 1'b1}));
		directed_rows.push_back(cfg_row(REG_WIDTH, 0));
		directed_rows.push_back(cfg_row(REG_HEIGHT, 0));
		directed_rows.push_back(pix_row({8'd10, 8'd20, 8'd30}, 1'b1,
			{8'd10, 8'd20, 8'd30, 1'b1, 1'b1}));
		// A 2x2 frame with two black pixels, then an all-black one.
		directed_rows.push_back(cfg_row(REG_SCALE, 2));
		directed_rows.push_back(cfg_row(REG_WIDTH, 2));
		directed_rows.push_back(cfg_row(REG_HEIGHT, 2));
		directed_rows.push_back(pix_row({8'd255, 8'd255, 8'd255}, 1'b0, '0));
		directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd0}, 1'b0, '0));
		directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd0}, 1'b0, '0));
		directed_rows.push_back(pix_row({8'd100, 8'd1, 8'd2}, 1'b1,
			{8'd177, 8'd128, 8'd128, 1'b1, 1'b1}));
		for (int i = 0; i < 3; i++)
			directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd0}, 1'b0, '0));
		directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd0}, 1'b1,
			{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}));
		// The third column is a partial block and must be dropped.
		directed_rows.push_back(cfg_row(REG_WIDTH, 3));
		for (int i = 0; i < 6; i++)
			directed_rows.push_back(pix_row({8'(40 * i + 3), 8'(200 - 30 * i), 8'(i)}, 1'b0, '0));
		// A frame smaller than one block gives nothing.
		directed_rows.push_back(cfg_row(REG_SCALE, 4));
		for (int i = 0; i < 6; i++)
			directed_rows.push_back(pix_row({8'(i + 1), 8'(i + 2), 8'(i + 3)}, 1'b0, '0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read(REG_SCALE, rd);
		check_field("scale_factor after reset", 32'(SCALE_RST), rd);
		@(posedge clk);
		apb_read(REG_WIDTH, rd);
		check_field("line_width after reset", 32'(WIDTH_RST), rd);
		@(posedge clk);
		apb_read(REG_HEIGHT, rd);
		check_field("frame_height after reset", 32'(HEIGHT_RST), rd);
		@(posedge clk);

		send_idle_pct = 17;
		recv_stall_pct = 58;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
			else
				send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].res);
		end

		// One full-width row at scale one writes every line store entry, so
		// later register changes in mid-frame never touch an unwritten entry.
		cfg_write(REG_SCALE, 1);
		cfg_write(REG_WIDTH, MAX_WIDTH_DEF);
		cfg_write(REG_HEIGHT, 1);
		repeat (MAX_WIDTH_DEF) send_pixel(random_pixel(), 1'b0, '0);

		for (int ph = 0; ph < 12; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 17;
					recv_stall_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			pick = (ph < 4) ? ph : $urandom_range(3, 9);
			case (pick)
				0: begin
					s = 15;
					w = $urandom_range(8, 20);
					h = 8191;
				end
				1: begin
					s = 1;
					w = 1;
					h = MAX_HEIGHT;
				end
				2: begin
					s = 0;
					w = 0;
					h = 0;
				end
				3: begin
					s = MAX_SCALE_DEF;
					w = $urandom_range(8, 24);
					h = $urandom_range(8, 16);
				end
				4: begin
					s = 1;
					w = 2047;
					h = $urandom_range(1, 3);
				end
				default: begin
					s = $urandom_range(1, 6);
					w = $urandom_range(1, 32);
					h = $urandom_range(1, 16);
				end
			endcase
			cfg_write(REG_SCALE, s);
			cfg_write(REG_WIDTH, w);
			cfg_write(REG_HEIGHT, h);
			repeat ($urandom_range(10, 24)) send_pixel(random_pixel(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LINGER_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
